@@ rtl/ccr_pkg.sv @@
// Package with the item types, character codes and queue sizing of the comment replacer.
`timescale 1ns / 1ps
`default_nettype none

package ccr_pkg;

    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } ccr_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } ccr_out_t;

    // Work for the emitter: one or two bytes caused by one item.
    typedef struct packed {
        logic       two;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } ccr_entry_t;

    typedef struct packed {
        logic       valid;
        ccr_entry_t entry;
    } ccr_push_t;

endpackage

`default_nettype wire

@@ rtl/ccr_front.sv @@
// Scanner front end: tracks the comment mode and turns each item into emitter work.
`timescale 1ns / 1ps
`default_nettype none

module ccr_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire ccr_pkg::ccr_in_t item,
    output ccr_pkg::ccr_push_t   push
);

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4
    } mode_t;

    mode_t      mode_reg;
    mode_t      mode_next;
    ccr_pkg::ccr_push_t work;

    always_comb
    begin
        mode_next               = mode_reg;
        work.valid              = 1'b0;
        work.entry.two          = 1'b0;
        work.entry.first_byte   = item.in_byte;
        work.entry.second_byte  = item.in_byte;
        if (item.end_of_input)
        begin
            // A held slash is released; any comment is abandoned.
            if (mode_reg == MODE_SLASH)
            begin
                work.valid            = 1'b1;
                work.entry.first_byte = ccr_pkg::CH_SLASH;
            end
            mode_next = MODE_NORMAL;
        end
        else
        begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    work.valid = 1'b1;
                    if (item.in_byte == ccr_pkg::CH_SLASH)
                    begin
                        work.entry.first_byte = ccr_pkg::CH_SPACE;
                        mode_next             = MODE_LINE;
                    end
                    else if (item.in_byte == ccr_pkg::CH_STAR)
                    begin
                        work.entry.first_byte = ccr_pkg::CH_SPACE;
                        mode_next             = MODE_BLOCK;
                    end
                    else
                    begin
                        work.entry.two        = 1'b1;
                        work.entry.first_byte = ccr_pkg::CH_SLASH;
                        mode_next             = MODE_NORMAL;
                    end
                end
                MODE_LINE:
                begin
                    if (item.in_byte == ccr_pkg::CH_NEWLINE)
                    begin
                        work.valid = 1'b1;
                        mode_next  = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (item.in_byte == ccr_pkg::CH_STAR)
                    begin
                        mode_next = MODE_STAR;
                    end
                end
                MODE_STAR:
                begin
                    if (item.in_byte == ccr_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (item.in_byte != ccr_pkg::CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
                default:
                begin
                    if (item.in_byte == ccr_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else
                    begin
                        work.valid = 1'b1;
                        mode_next  = MODE_NORMAL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
        end
    end

    assign push.valid = accept && work.valid;
    assign push.entry = work.entry;

endmodule

`default_nettype wire

@@ rtl/ccr_queue.sv @@
// Short queue of emitter work between the scanner and the emitter.
`timescale 1ns / 1ps
`default_nettype none

module ccr_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ccr_pkg::ccr_push_t push,
    input  wire logic               pop,
    output logic                    full,
    output logic                    empty,
    output ccr_pkg::ccr_entry_t     head
);

    ccr_pkg::ccr_entry_t               slot_reg [ccr_pkg::QUEUE_DEPTH];
    logic [ccr_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [ccr_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [ccr_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [ccr_pkg::QUEUE_CNT_W-1:0]   count_next;

    assign full  = (count_reg == ccr_pkg::QUEUE_CNT_W'(ccr_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ccr_emitter.sv @@
// Emitter back end: sends the one or two bytes of each queued entry through an output register.
`timescale 1ns / 1ps
`default_nettype none

module ccr_emitter (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                empty,
    input  wire ccr_pkg::ccr_entry_t head,
    output logic                     pop,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output ccr_pkg::ccr_out_t        result
);

    logic              valid_reg;
    logic              second_reg;
    ccr_pkg::ccr_out_t data_reg;
    logic              load;

    // The output register takes a new byte when work is queued and it is empty or being drained.
    assign load = !empty && (!valid_reg || result_ready);
    assign pop  = load && (second_reg || !head.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg  <= 1'b1;
                second_reg <= !second_reg && head.two;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.out_byte    <= second_reg ? head.second_byte : head.first_byte;
            data_reg.last_of_run <= second_reg || !head.two;
        end
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

`default_nettype wire

@@ rtl/c_comment_replacer_top.sv @@
// Top level of the C comment replacer: scanner, work queue and emitter.
`timescale 1ns / 1ps
`default_nettype none

// Replaces every C comment in a byte stream with one space; a line comment keeps its
// newline, and a lone slash is sent just before the byte after it, so one item can give
// two results (the slash with last_of_run low, then the byte). End of stream flushes a
// held slash and returns to normal mode. One item is accepted per clock while the
// four-entry work queue has room; the emitter delivers one result per clock while work is
// queued and results are taken, and the queue absorbs items that give two results. The first
// result of an item is registered in the work queue, then in the output register.
module c_comment_replacer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire ccr_pkg::ccr_in_t  item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output ccr_pkg::ccr_out_t      result
);

    ccr_pkg::ccr_push_t  push;
    ccr_pkg::ccr_entry_t head;
    logic                full;
    logic                empty;
    logic                pop;
    logic                accept;

    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    ccr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push)
    );

    ccr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (full),
        .empty (empty),
        .head  (head)
    );

    ccr_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ rtl/ccr_checker.sv @@
// Port checker for the comment replacer, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module ccr_port_props (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              item_valid,
    input wire logic              item_ready,
    input wire ccr_pkg::ccr_in_t  item,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire ccr_pkg::ccr_out_t result
);

    // A held result stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Only a released slash can be the first of two results.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_of_run |-> result.out_byte == ccr_pkg::CH_SLASH)
        else $error("first of two results is not a slash");

    // The second result of an item follows right after the first is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_of_run
            |=> result_valid && result.last_of_run)
        else $error("second result of an item did not follow");

    // Handshake signals and offered results are always known.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({item_ready, result_valid})
            && (!result_valid || !$isunknown(result)))
        else $error("unknown value on the output side");

    // An accepted item carries known fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |-> !$isunknown(item))
        else $error("unknown item accepted");

endmodule

bind c_comment_replacer_top ccr_port_props u_ccr_port_props (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

@@ tb/ccr_checker.sv @@
// Checker for the comment replacer: predicts the output bytes of every item and compares them.
`timescale 1ns / 1ps

module ccr_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  ccr_pkg::ccr_in_t  item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  ccr_pkg::ccr_out_t result,
    output int                mismatch_count,
    output int                outstanding
);

    typedef enum logic [2:0] {
        SCAN_NORMAL,
        SCAN_SLASH,
        SCAN_LINE,
        SCAN_BLOCK,
        SCAN_STAR
    } scan_t;

    scan_t             scan_state;
    ccr_pkg::ccr_out_t expected_chars[$];

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR at %0t: %s got %02h expected %02h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic expect_char(input logic [7:0] ch, input logic last);
        ccr_pkg::ccr_out_t r;
        r.out_byte    = ch;
        r.last_of_run = last;
        expected_chars.push_back(r);
    endtask

    // Advances the scanner by one item and queues the bytes it must emit.
    task automatic predict_strip(input ccr_pkg::ccr_in_t it);
        logic [7:0] c;
        c = it.in_byte;
        if (it.end_of_input)
        begin
            if (scan_state == SCAN_SLASH)
                expect_char(ccr_pkg::CH_SLASH, 1'b1);
            scan_state = SCAN_NORMAL;
        end
        else
        begin
            case (scan_state)
                SCAN_SLASH:
                begin
                    if (c == ccr_pkg::CH_SLASH)
                    begin
                        expect_char(ccr_pkg::CH_SPACE, 1'b1);
                        scan_state = SCAN_LINE;
                    end
                    else if (c == ccr_pkg::CH_STAR)
                    begin
                        expect_char(ccr_pkg::CH_SPACE, 1'b1);
                        scan_state = SCAN_BLOCK;
                    end
                    else
                    begin
                        // The held slash goes out first, then the byte itself.
                        expect_char(ccr_pkg::CH_SLASH, 1'b0);
                        expect_char(c, 1'b1);
                        scan_state = SCAN_NORMAL;
                    end
                end
                SCAN_LINE:
                begin
                    if (c == ccr_pkg::CH_NEWLINE)
                    begin
                        expect_char(c, 1'b1);
                        scan_state = SCAN_NORMAL;
                    end
                end
                SCAN_BLOCK:
                begin
                    if (c == ccr_pkg::CH_STAR)
                        scan_state = SCAN_STAR;
                end
                SCAN_STAR:
                begin
                    if (c == ccr_pkg::CH_SLASH)
                        scan_state = SCAN_NORMAL;
                    else if (c != ccr_pkg::CH_STAR)
                        scan_state = SCAN_BLOCK;
                end
                default:
                begin
                    if (c == ccr_pkg::CH_SLASH)
                    begin
                        scan_state = SCAN_SLASH;
                    end
                    else
                    begin
                        expect_char(c, 1'b1);
                        scan_state = SCAN_NORMAL;
                    end
                end
            endcase
        end
    endtask

    task automatic check_result(input ccr_pkg::ccr_out_t got);
        ccr_pkg::ccr_out_t want;
        if (expected_chars.size() == 0)
        begin
            report_mismatch("unexpected result, out_byte", got.out_byte, 8'h00);
        end
        else
        begin
            want = expected_chars.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", {7'd0, got.last_of_run},
                                {7'd0, want.last_of_run});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state     = SCAN_NORMAL;
            mismatch_count = 0;
            expected_chars.delete();
        end
        else
        begin
            if (item_valid && item_ready)
                predict_strip(item);
            if (result_valid && result_ready)
                check_result(result);
        end
        outstanding = expected_chars.size();
    end

endmodule

@@ tb/tb_c_comment_replacer_top.sv @@
// Testbench top for the comment replacer: clock, reset, byte stream, output stalls and verdict.
`timescale 1ns / 1ps

module tb_c_comment_replacer_top;

    localparam int NUM_ITEMS      = 1400;
    localparam int WATCHDOG_LIMIT = 5000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    ccr_pkg::ccr_in_t  item = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    ccr_pkg::ccr_out_t result;

    int mismatch_count;
    int outstanding;
    int sent_count = 0;
    int burst_left = 4;
    int idle_cycles = 0;

    c_comment_replacer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    ccr_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Offers one item, holds it until taken, then maybe leaves a gap before the next one.
    task automatic send(input ccr_pkg::ccr_in_t it);
        int gap;
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        sent_count++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        ccr_pkg::ccr_in_t it;
        it.in_byte      = b;
        it.end_of_input = 1'b0;
        send(it);
    endtask

    task automatic send_eos();
        ccr_pkg::ccr_in_t it;
        it.in_byte      = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        send(it);
    endtask

    // Source-like byte: slashes, stars and newlines turn up far more than chance would give.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0, 1:    return ccr_pkg::CH_SLASH;
            2, 3:    return ccr_pkg::CH_STAR;
            4:       return ccr_pkg::CH_NEWLINE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_line_comment();
        int len;
        logic [7:0] b;
        len = $urandom_range(0, 10);
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_SLASH);
        repeat (len)
        begin
            b = pick_byte();
            if (b == ccr_pkg::CH_NEWLINE)
                b = ccr_pkg::CH_STAR;
            send_byte(b);
        end
        if ($urandom_range(0, 19) == 0)
            send_eos();
        else
            send_byte(ccr_pkg::CH_NEWLINE);
    endtask

    task automatic send_block_comment();
        int len;
        len = $urandom_range(0, 10);
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_STAR);
        repeat (len) send_byte(pick_byte());
        if ($urandom_range(0, 19) == 0)
        begin
            send_eos();
        end
        else
        begin
            repeat ($urandom_range(1, 3)) send_byte(ccr_pkg::CH_STAR);
            send_byte(ccr_pkg::CH_SLASH);
        end
    endtask

    task automatic send_random_token();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 50)
        begin
            send_line_comment();
        end
        else if (kind < 75)
        begin
            send_block_comment();
        end
        else if (kind < 87)
        begin
            send_byte(ccr_pkg::CH_SLASH);
            send_byte(pick_byte());
        end
        else if (kind < 92)
        begin
            send_eos();
        end
        else
        begin
            repeat ($urandom_range(1, 6)) send_byte(pick_byte());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slash before an ordinary byte gives two results; extremes of the byte range.
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(8'h00);
        send_byte(8'hFF);
        // Line comment keeps only its newline.
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(8'h78);
        send_byte(ccr_pkg::CH_NEWLINE);
        // The opening star must not close the comment; repeated stars then a close.
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_STAR);
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_STAR);
        send_byte(ccr_pkg::CH_STAR);
        send_byte(8'h71);
        send_byte(ccr_pkg::CH_STAR);
        send_byte(ccr_pkg::CH_SLASH);
        // End of stream with a held slash, in normal mode, and inside each comment mode.
        send_byte(ccr_pkg::CH_SLASH);
        send_eos();
        send_eos();
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_SLASH);
        send_eos();
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_STAR);
        send_eos();
        send_byte(ccr_pkg::CH_SLASH);
        send_byte(ccr_pkg::CH_STAR);
        send_byte(ccr_pkg::CH_STAR);
        send_eos();

        while (sent_count < NUM_ITEMS)
            send_random_token();
        item_valid <= 1'b0;

        // Let the checker take in the last accepted item before its count is read.
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output side: open stretches, random stalls, full stalls, and two long hold-offs
    // that let the work queue fill and back up the input.
    initial
    begin
        int rx_cycles;
        int holds_done;
        int phase;
        int len;
        rx_cycles  = 0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            if ((holds_done == 0 && rx_cycles > 300) || (holds_done == 1 && rx_cycles > 2000))
            begin
                holds_done++;
                for (int i = 0; i < 120; i++)
                begin
                    result_ready <= 1'b0;
                    @(posedge clk);
                    rx_cycles++;
                end
            end
            phase = $urandom_range(0, 9);
            len   = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
            begin
                if (phase < 4)
                    result_ready <= 1'b1;
                else if (phase < 8)
                    result_ready <= 1'($urandom_range(0, 1));
                else
                    result_ready <= (i >= 8);
                @(posedge clk);
                rx_cycles++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

@@ files.f @@
rtl/ccr_pkg.sv
rtl/ccr_front.sv
rtl/ccr_queue.sv
rtl/ccr_emitter.sv
rtl/c_comment_replacer_top.sv
rtl/ccr_checker.sv
tb/ccr_checker.sv
tb/tb_c_comment_replacer_top.sv
